>>> rtl/nearest_of_four_palette_match_unit_macros.svh
// ----------------------------------------------------------------------------
// nearest-of-four palette match assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef NEAREST_OF_FOUR_PALETTE_MATCH_UNIT_MACROS_SVH
`define NEAREST_OF_FOUR_PALETTE_MATCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check gated off while reset is held
`define NOFPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also runs through reset
`define NOFPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NOFPM_ASSERT(lbl, clk, rstn, prop, msg)
`define NOFPM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/nofpm_pkg.sv
// ----------------------------------------------------------------------------
// nofpm_pkg
// shared widths, types and slot codes of the palette match unit
// ----------------------------------------------------------------------------
`default_nettype none

package nofpm_pkg;

    localparam int RGB_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int DIST_W    = SQ_W + 2;   // three squares summed
    localparam int SLOT_W    = 2;
    localparam int NUM_SLOTS = 4;

    typedef logic [RGB_W-1:0]  t_rgb;
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [SQ_W-1:0]   t_sq;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_slot SLOT_CELL_A = 2'd0;
    localparam t_slot SLOT_CELL_B = 2'd1;
    localparam t_slot SLOT_LINE_A = 2'd2;
    localparam t_slot SLOT_LINE_B = 2'd3;

    localparam t_rgb NONE_COLOR = '0;

endpackage

`default_nettype wire

>>> rtl/nofpm_ifs.sv
// ----------------------------------------------------------------------------
// nofpm channel interfaces
// pixel item channel and result item channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface nofpm_pix_if;
    import nofpm_pkg::*;

    logic valid;
    logic ready;
    t_rgb pixel_color;
    t_rgb cell_color_a;
    logic cell_a_valid;
    t_rgb cell_color_b;
    logic cell_b_valid;
    t_rgb line_color_a;
    logic line_a_valid;
    t_rgb line_color_b;
    logic line_b_valid;

    modport source (
        output valid, pixel_color, cell_color_a, cell_a_valid, cell_color_b,
               cell_b_valid, line_color_a, line_a_valid, line_color_b, line_b_valid,
        input  ready
    );

    modport sink (
        input  valid, pixel_color, cell_color_a, cell_a_valid, cell_color_b,
               cell_b_valid, line_color_a, line_a_valid, line_color_b, line_b_valid,
        output ready
    );
endinterface

interface nofpm_res_if;
    import nofpm_pkg::*;

    logic  valid;
    logic  ready;
    t_rgb  mapped_color;
    t_slot chosen_slot;
    logic  exact_hit;
    logic  none_valid;
    logic  changed;

    modport source (
        output valid, mapped_color, chosen_slot, exact_hit, none_valid, changed,
        input  ready
    );

    modport sink (
        input  valid, mapped_color, chosen_slot, exact_hit, none_valid, changed,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/nofpm_dist.sv
// ----------------------------------------------------------------------------
// nofpm_dist
// squared rgb distance and exact compare of one candidate against the pixel
// ----------------------------------------------------------------------------
`default_nettype none

module nofpm_dist (
    input  nofpm_pkg::t_rgb  i_pixel,
    input  nofpm_pkg::t_rgb  i_cand,
    output nofpm_pkg::t_dist o_dist,
    output logic             o_equal
);
    import nofpm_pkg::*;

    t_chan w_diff [3];
    t_sq   w_sq   [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (i_pixel[c*CHAN_W +: CHAN_W] > i_cand[c*CHAN_W +: CHAN_W]) begin
                w_diff[c] = i_pixel[c*CHAN_W +: CHAN_W] - i_cand[c*CHAN_W +: CHAN_W];
            end else begin
                w_diff[c] = i_cand[c*CHAN_W +: CHAN_W] - i_pixel[c*CHAN_W +: CHAN_W];
            end
            w_sq[c] = SQ_W'(w_diff[c]) * SQ_W'(w_diff[c]);
        end
    end

    // max sum 3*255*255 fits the distance width
    assign o_dist  = DIST_W'(w_sq[0]) + DIST_W'(w_sq[1]) + DIST_W'(w_sq[2]);
    assign o_equal = (i_pixel == i_cand);

endmodule

`default_nettype wire

>>> rtl/nearest_of_four_palette_match_unit.sv
// ----------------------------------------------------------------------------
// nearest_of_four_palette_match_unit
// maps one rgb888 pixel onto the nearest of four candidate palette colors
// ----------------------------------------------------------------------------
// usage
//   i_pix carries one item per pixel: the pixel color and four candidate
//   colors (cell a, cell b, line a, line b), each with its own valid bit
//   o_res returns one item per pixel: mapped color, chosen slot and the
//   exact hit, none valid and changed flags, in input order
//   an exact match wins in slot order, else the least squared rgb distance
//   among valid candidates, ties to the lower slot; no valid candidate
//   gives color 0, slot 0 and none_valid set
//   an accepted item goes into the input register, and its result then
//   into the result register, which drives o_res
//   throughput: one item per cycle while o_res does not stall, set by the
//   single registered pass of twelve 8x8 squarers and a two-level compare tree
//   reset clears both stage valid bits; no result is shown afterwards
//   when o_res stalls, the result and a full input stage hold; i_pix.ready
//   drops only once both stages are full and the receiver still stalls
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_of_four_palette_match_unit_macros.svh"

module nearest_of_four_palette_match_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nofpm_pix_if.sink   i_pix,
    nofpm_res_if.source o_res
);
    import nofpm_pkg::*;

    // input stage item
    typedef struct packed {
        t_rgb                  pixel;
        t_rgb [NUM_SLOTS-1:0]  cand;
        logic [NUM_SLOTS-1:0]  ok;
    } t_stg_item;

    // result item
    typedef struct packed {
        t_rgb  color;
        t_slot slot;
        logic  exact;
        logic  none;
        logic  changed;
    } t_res_item;

    logic      r_stg_valid, n_stg_valid;
    t_stg_item r_stg;
    logic      r_res_valid, n_res_valid;
    t_res_item r_res, n_res;

    logic w_adv_res;   // result register takes a new value
    logic w_adv_stg;   // input register takes a new value

    // handshake: each stage moves when the stage after it has room
    assign w_adv_res   = !r_res_valid || o_res.ready;
    assign w_adv_stg   = !r_stg_valid || w_adv_res;
    assign i_pix.ready = w_adv_stg;

    always_comb begin
        n_stg_valid = r_stg_valid;
        n_res_valid = r_res_valid;
        if (w_adv_stg) begin
            n_stg_valid = i_pix.valid;
        end
        if (w_adv_res) begin
            n_res_valid = r_stg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_stg_valid <= n_stg_valid;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_adv_stg) begin
            r_stg.pixel   <= i_pix.pixel_color;
            r_stg.cand[0] <= i_pix.cell_color_a;
            r_stg.cand[1] <= i_pix.cell_color_b;
            r_stg.cand[2] <= i_pix.line_color_a;
            r_stg.cand[3] <= i_pix.line_color_b;
            r_stg.ok      <= {i_pix.line_b_valid, i_pix.line_a_valid,
                              i_pix.cell_b_valid, i_pix.cell_a_valid};
        end
        if (w_adv_res) begin
            r_res <= n_res;
        end
    end

    // per-candidate distance and exact compare
    t_dist                w_dist [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_equal;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_dist
        nofpm_dist u_dist (
            .i_pixel (r_stg.pixel),
            .i_cand  (r_stg.cand[g]),
            .o_dist  (w_dist[g]),
            .o_equal (w_equal[g])
        );
    end

    // compare tree: the upper entry wins only if valid and the lower is invalid or
    // strictly farther, so ties and exact matches resolve to the lowest slot
    logic  w_pick_b, w_pick_d, w_pick_hi;
    logic  w_ok_lo, w_ok_hi;
    t_dist w_dist_lo, w_dist_hi;
    t_slot w_slot_lo, w_slot_hi, w_slot_win;
    logic  w_exact;

    always_comb begin
        w_pick_b  = r_stg.ok[1] && (!r_stg.ok[0] || (w_dist[1] < w_dist[0]));
        w_pick_d  = r_stg.ok[3] && (!r_stg.ok[2] || (w_dist[3] < w_dist[2]));
        w_ok_lo   = r_stg.ok[0] || r_stg.ok[1];
        w_ok_hi   = r_stg.ok[2] || r_stg.ok[3];
        w_dist_lo = w_pick_b ? w_dist[1] : w_dist[0];
        w_dist_hi = w_pick_d ? w_dist[3] : w_dist[2];
        w_slot_lo = w_pick_b ? SLOT_CELL_B : SLOT_CELL_A;
        w_slot_hi = w_pick_d ? SLOT_LINE_B : SLOT_LINE_A;
        w_pick_hi = w_ok_hi && (!w_ok_lo || (w_dist_hi < w_dist_lo));
        w_slot_win = w_pick_hi ? w_slot_hi : w_slot_lo;
        w_exact   = |(w_equal & r_stg.ok);

        n_res.exact = w_exact;
        n_res.none  = !(w_ok_lo || w_ok_hi);
        if (n_res.none) begin
            n_res.slot  = SLOT_CELL_A;
            n_res.color = NONE_COLOR;
        end else begin
            n_res.slot  = w_slot_win;
            n_res.color = r_stg.cand[w_slot_win];
        end
        n_res.changed = (n_res.color != r_stg.pixel);
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.mapped_color = r_res.color;
    assign o_res.chosen_slot  = r_res.slot;
    assign o_res.exact_hit    = r_res.exact;
    assign o_res.none_valid   = r_res.none;
    assign o_res.changed      = r_res.changed;

    // checks
    `NOFPM_ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (!r_stg_valid && !r_res_valid), "stage valid left set after reset")
    `NOFPM_ASSERT(a_accept_fills, i_clk, i_rst_n,
        (i_pix.valid && i_pix.ready) |=> r_stg_valid, "accepted item missing in input stage")
    `NOFPM_ASSERT(a_stage_moves, i_clk, i_rst_n,
        (r_stg_valid && w_adv_res) |=> r_res_valid, "input stage item not moved to result")
    `NOFPM_ASSERT(a_exact_result, i_clk, i_rst_n,
        (r_stg_valid && w_adv_res && w_exact) |=>
        (o_res.exact_hit && !o_res.changed && !o_res.none_valid),
        "exact match gave a changed result")

endmodule

`default_nettype wire
